// ===== rtl/bfm_pkg.sv =====
// Shared constants and types of the 3x3 box mean filter.
`default_nettype none

package bfm_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 16;

   localparam int CFG_BITS       = 11;
   localparam int HEIGHT_BITS    = 16;
   localparam int HEIGHT_LIMIT   = 1024;
   localparam int ROW_BITS       = 10;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_BITS-1:0]       FRAME_SIZE_RESET = 11'd1024;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   localparam int FIFO_DEPTH      = 16;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam int MEAN_STAGES     = 5;
   localparam int MEAN_COUNT_BITS = $clog2(MEAN_STAGES + 1);

   typedef struct packed {
      logic                   mode;
      logic [HEIGHT_BITS-1:0] height;
   } req_payload_type;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] filtered_height;
      logic                   frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic use_mean;
      logic frame_end;
   } mean_tag_type;

endpackage

`default_nettype wire

// ===== rtl/bfm_line_store.sv =====
// Two line buffer memories with registered reads and write-to-read forwarding.
`default_nettype none

module bfm_line_store #(
   parameter int DEPTH     = bfm_pkg::MAX_WIDTH_DEFAULT,
   parameter int DATA_BITS = bfm_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_BITS-1:0]       wr_upper,
   input  wire logic [DATA_BITS-1:0]       wr_middle,
   output logic      [DATA_BITS-1:0]       rd_upper,
   output logic      [DATA_BITS-1:0]       rd_middle
);
   import bfm_pkg::*;

   logic [DATA_BITS-1:0] upper_mem_ff  [DEPTH];
   logic [DATA_BITS-1:0] middle_mem_ff [DEPTH];
   logic [DATA_BITS-1:0] upper_q_ff;
   logic [DATA_BITS-1:0] middle_q_ff;
   logic [DATA_BITS-1:0] fwd_upper_ff;
   logic [DATA_BITS-1:0] fwd_middle_ff;
   logic                 fwd_ff;
   logic                 fwd_in;

   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem_ff[wr_addr]  <= wr_upper;
         middle_mem_ff[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         upper_q_ff    <= upper_mem_ff[rd_addr];
         middle_q_ff   <= middle_mem_ff[rd_addr];
         fwd_upper_ff  <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : upper_q_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : middle_q_ff;

endmodule

`default_nettype wire

// ===== rtl/bfm_mean.sv =====
// Pipelined nine-term sum and divide by nine with border pass-through.
`default_nettype none

module bfm_mean #(
   parameter int PIXEL_BITS = bfm_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [2:0][2:0][PIXEL_BITS-1:0]        window,
   input  wire logic [PIXEL_BITS-1:0]                  pass_value,
   input  wire bfm_pkg::mean_tag_type                  in_tag,
   output logic                                        out_valid,
   output logic      [PIXEL_BITS-1:0]                  out_value,
   output bfm_pkg::mean_tag_type                       out_tag,
   output logic      [bfm_pkg::MEAN_COUNT_BITS-1:0]    inflight
);
   import bfm_pkg::*;

   localparam int DIVISOR    = 9;
   localparam int ROW_BITS_S = PIXEL_BITS + 2;
   localparam int SUM_BITS   = PIXEL_BITS + 4;
   localparam int SHIFT      = SUM_BITS;
   localparam int RECIP_BITS = SUM_BITS - 3;
   localparam int LO_BITS    = SUM_BITS / 2;
   localparam int HI_BITS    = SUM_BITS - LO_BITS;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((64'd1 << SHIFT) / 64'(DIVISOR));

   logic [MEAN_STAGES-1:0] valid_ff;
   logic [MEAN_STAGES-1:0] valid_in;
   mean_tag_type           tag_ff [MEAN_STAGES];
   logic [PIXEL_BITS-1:0]  pass_ff [MEAN_STAGES];

   logic [2:0][ROW_BITS_S-1:0]      row_sum_ff;
   logic [2:0][ROW_BITS_S-1:0]      row_sum_in;
   logic [SUM_BITS-1:0]             sum2_ff;
   logic [SUM_BITS-1:0]             sum2_in;
   logic [SUM_BITS-1:0]             sum3_ff;
   logic [SUM_BITS-1:0]             sum4_ff;
   logic [HI_BITS+RECIP_BITS-1:0]   prod_hi_ff;
   logic [HI_BITS+RECIP_BITS-1:0]   prod_hi_in;
   logic [LO_BITS+RECIP_BITS-1:0]   prod_lo_ff;
   logic [LO_BITS+RECIP_BITS-1:0]   prod_lo_in;
   logic [PROD_BITS-1:0]            prod_sum;
   logic [PIXEL_BITS-1:0]           quot_ff;
   logic [PIXEL_BITS-1:0]           quot_in;
   logic [SUM_BITS-1:0]             rem;
   logic [PIXEL_BITS-1:0]           mean_val;
   logic [PIXEL_BITS-1:0]           value_ff;
   logic [PIXEL_BITS-1:0]           value_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum_in[r] = ROW_BITS_S'(window[r][0]) + ROW_BITS_S'(window[r][1])
                       + ROW_BITS_S'(window[r][2]);
      end
      sum2_in    = SUM_BITS'(row_sum_ff[0]) + SUM_BITS'(row_sum_ff[1])
                 + SUM_BITS'(row_sum_ff[2]);
      prod_hi_in = (HI_BITS+RECIP_BITS)'(sum2_ff[SUM_BITS-1:LO_BITS])
                 * (HI_BITS+RECIP_BITS)'(RECIP);
      prod_lo_in = (LO_BITS+RECIP_BITS)'(sum2_ff[LO_BITS-1:0])
                 * (LO_BITS+RECIP_BITS)'(RECIP);
      prod_sum   = (PROD_BITS'(prod_hi_ff) << LO_BITS) + PROD_BITS'(prod_lo_ff);
      quot_in    = prod_sum[SHIFT +: PIXEL_BITS];
      rem        = sum4_ff - SUM_BITS'(quot_ff) * SUM_BITS'(DIVISOR);
      mean_val   = (rem >= SUM_BITS'(DIVISOR)) ? quot_ff + PIXEL_BITS'(1) : quot_ff;
      value_in   = tag_ff[MEAN_STAGES-2].use_mean ? mean_val : pass_ff[MEAN_STAGES-2];
      valid_in   = {valid_ff[MEAN_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0]  <= in_tag;
      pass_ff[0] <= pass_value;
      for (int s = 1; s < MEAN_STAGES; s++) begin
         tag_ff[s]  <= tag_ff[s-1];
         pass_ff[s] <= pass_ff[s-1];
      end
      row_sum_ff <= row_sum_in;
      sum2_ff    <= sum2_in;
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      sum3_ff    <= sum2_ff;
      quot_ff    <= quot_in;
      sum4_ff    <= sum3_ff;
      value_ff   <= value_in;
   end

   assign out_valid = valid_ff[MEAN_STAGES-1];
   assign out_value = value_ff;
   assign out_tag   = tag_ff[MEAN_STAGES-1];
   assign inflight  = MEAN_COUNT_BITS'($countones(valid_ff));

endmodule

`default_nettype wire

// ===== rtl/bfm_out_fifo.sv =====
// Result queue between the filter pipeline and the result channel.
`default_nettype none

module bfm_out_fifo (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire bfm_pkg::rsp_payload_type             push_data,
   input  wire logic                                 pop,
   output logic                                      out_valid,
   output bfm_pkg::rsp_payload_type                  out_data,
   output logic      [bfm_pkg::FIFO_COUNT_BITS-1:0]  count
);
   import bfm_pkg::*;

   rsp_payload_type            entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff;
   logic [FIFO_COUNT_BITS-1:0] count_ff;
   logic [FIFO_COUNT_BITS-1:0] count_in;
   logic                       pop_fire;

   assign pop_fire = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop_fire) begin
         count_in = count_ff + FIFO_COUNT_BITS'(1);
      end else if (!push && pop_fire) begin
         count_in = count_ff - FIFO_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/box_filter_3x3_mean_unit.sv =====
// Top level of the 3x3 box mean filter: raster control, window and line buffers.
// Throughput: one item per cycle, set by the single read-modify-write of the line buffers.
// Once the item that releases a result is accepted, the result passes through the line
// buffer read, window, five mean stages and result queue; intake stops while 16 results
// are queued or in flight. Reset is synchronous: it clears the counters, window and queue,
// sets both sizes to 1024; line buffers are not cleared and need no clearing pass.
`default_nettype none

module box_filter_3x3_mean_unit #(
   parameter int MAX_WIDTH  = bfm_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = bfm_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [bfm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bfm_pkg::CFG_BITS-1:0]         csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire bfm_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output bfm_pkg::rsp_payload_type                  rsp_payload
);
   import bfm_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int CW       = ($clog2(MAX_WIDTH + 3) > CFG_BITS + 1) ?
                             $clog2(MAX_WIDTH + 3) : CFG_BITS + 1;
   localparam int OCC_BITS = $clog2(FIFO_DEPTH + MEAN_STAGES + 3);

   logic [CFG_BITS-1:0] frame_width_ff;
   logic [CFG_BITS-1:0] frame_height_ff;

   logic [COL_BITS-1:0] in_col_ff,  in_col_in;
   logic [ROW_BITS-1:0] in_row_ff,  in_row_in;
   logic [COL_BITS-1:0] out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;
   logic [CW-1:0]       pending_ff, pending_in;

   logic [CW-1:0]       eff_w;
   logic [CW-1:0]       fw_ext;
   logic [CFG_BITS-1:0] eff_h;
   logic                acc;
   logic                at_start;
   logic                is_drain;
   logic                restart;
   logic [CW-1:0]       pend_base;
   logic [CW-1:0]       pend_inc;
   logic [ROW_BITS-1:0] orow_base;
   logic [COL_BITS-1:0] ocol_base;
   logic [ROW_BITS:0]   orow_next1;
   logic [CW-1:0]       ocol_next1;
   logic [ROW_BITS:0]   irow_next1;
   logic [CW-1:0]       icol_next1;
   logic                out_last_row;
   logic                out_last_col;
   logic                border;
   logic                drain_emit;
   logic                px_emit;
   logic                emit;
   logic [PIXEL_BITS-1:0] pixel;

   logic                  s1_valid_ff;
   logic                  s1_pixel_ff;
   logic                  s1_emit_ff;
   logic                  s1_mid_sel_ff;
   logic [COL_BITS-1:0]   s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_value_ff;
   mean_tag_type          s1_tag_ff;
   mean_tag_type          s1_tag_in;

   logic                  s2_valid_ff;
   logic                  s2_pixel_ff;
   logic [PIXEL_BITS-1:0] s2_drain_value_ff;
   mean_tag_type          s2_tag_ff;

   logic [2:0][2:0][PIXEL_BITS-1:0] window_ff;

   logic                  rd_en;
   logic [COL_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [PIXEL_BITS-1:0] rd_upper;
   logic [PIXEL_BITS-1:0] rd_middle;

   logic [PIXEL_BITS-1:0]      pass_value;
   logic                       mean_valid;
   logic [PIXEL_BITS-1:0]      mean_value;
   mean_tag_type               mean_tag;
   logic [MEAN_COUNT_BITS-1:0] mean_inflight;
   rsp_payload_type            push_data;
   logic [FIFO_COUNT_BITS-1:0] fifo_count;
   logic [OCC_BITS-1:0]        occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fw_ext = CW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         eff_w = CW'(1);
      end else if (fw_ext > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      if (frame_height_ff == '0) begin
         eff_h = CFG_BITS'(1);
      end else if (frame_height_ff > CFG_BITS'(HEIGHT_LIMIT)) begin
         eff_h = CFG_BITS'(HEIGHT_LIMIT);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   assign occupancy = OCC_BITS'(fifo_count) + OCC_BITS'(s1_valid_ff && s1_emit_ff)
                    + OCC_BITS'(s2_valid_ff) + OCC_BITS'(mean_inflight);
   assign req_ready = (occupancy < OCC_BITS'(FIFO_DEPTH));
   assign acc       = req_valid && req_ready;
   assign pixel     = PIXEL_BITS'(req_payload.height);

   always_comb begin
      at_start     = (in_row_ff == '0) && (in_col_ff == '0);
      is_drain     = (req_payload.mode == MODE_DRAIN);
      restart      = !is_drain && at_start && (pending_ff != '0);
      pend_base    = restart ? '0 : pending_ff;
      orow_base    = restart ? '0 : out_row_ff;
      ocol_base    = restart ? '0 : out_col_ff;
      orow_next1   = {1'b0, orow_base} + (ROW_BITS+1)'(1);
      ocol_next1   = CW'(ocol_base) + CW'(1);
      out_last_row = ((ROW_BITS+1)'(orow_next1) >= (ROW_BITS+1)'(eff_h));
      out_last_col = (ocol_next1 >= eff_w);
      border       = (orow_base == '0) || out_last_row || (ocol_base == '0) || out_last_col;
      pend_inc     = pend_base + CW'(1);
      drain_emit   = is_drain && (pending_ff != '0) && at_start;
      px_emit      = !is_drain && (pend_inc > eff_w + CW'(1));
      emit         = drain_emit || px_emit;
      irow_next1   = {1'b0, in_row_ff} + (ROW_BITS+1)'(1);
      icol_next1   = CW'(in_col_ff) + CW'(1);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;

      if (acc) begin
         if (!is_drain) begin
            if (icol_next1 >= eff_w) begin
               in_col_in = '0;
               in_row_in = ((ROW_BITS+1)'(irow_next1) >= (ROW_BITS+1)'(eff_h)) ?
                           '0 : irow_next1[ROW_BITS-1:0];
            end else begin
               in_col_in = icol_next1[COL_BITS-1:0];
            end
            pending_in = pend_inc;
            out_col_in = ocol_base;
            out_row_in = orow_base;
         end
         if (emit) begin
            pending_in = (is_drain ? pending_ff : pend_inc) - CW'(1);
            if (out_last_col) begin
               out_col_in = '0;
               out_row_in = out_last_row ? '0 : orow_next1[ROW_BITS-1:0];
            end else begin
               out_col_in = ocol_next1[COL_BITS-1:0];
            end
         end
      end

      s1_tag_in.use_mean  = !is_drain && !border;
      s1_tag_in.frame_end = out_last_row && out_last_col;
      rd_en   = acc && (!is_drain || drain_emit);
      rd_addr = is_drain ? out_col_ff : in_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pending_ff  <= pending_in;
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pixel_ff   <= !is_drain;
         s1_emit_ff    <= emit;
         s1_mid_sel_ff <= out_last_row;
         s1_addr_ff    <= rd_addr;
         s1_value_ff   <= pixel;
         s1_tag_ff     <= s1_tag_in;
      end
      s2_pixel_ff       <= s1_pixel_ff;
      s2_drain_value_ff <= s1_mid_sel_ff ? rd_middle : rd_upper;
      s2_tag_ff         <= s1_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r][0] <= window_ff[r][1];
            window_ff[r][1] <= window_ff[r][2];
         end
         window_ff[0][2] <= rd_upper;
         window_ff[1][2] <= rd_middle;
         window_ff[2][2] <= s1_value_ff;
      end
   end

   assign wr_en = s1_valid_ff && s1_pixel_ff;

   bfm_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_upper  (rd_middle),
      .wr_middle (s1_value_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   assign pass_value = s2_pixel_ff ? window_ff[1][1] : s2_drain_value_ff;

   bfm_mean #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_mean (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid_ff),
      .window     (window_ff),
      .pass_value (pass_value),
      .in_tag     (s2_tag_ff),
      .out_valid  (mean_valid),
      .out_value  (mean_value),
      .out_tag    (mean_tag),
      .inflight   (mean_inflight)
   );

   always_comb begin
      push_data.filtered_height = HEIGHT_BITS'(mean_value);
      push_data.frame_end       = mean_tag.frame_end;
   end

   bfm_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mean_valid),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .count     (fifo_count)
   );

endmodule

`default_nettype wire

// ===== verif/tb_box_filter_3x3_mean_unit.sv =====
// Testbench for the 3x3 box mean filter: raster frames with resizes, checked against a pixel model.
`timescale 1ns / 100ps

module tb_box_filter_3x3_mean_unit;
   import bfm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_SETTLE  = 16;
   localparam int LONG_HOLD    = 300;
   localparam int WINDOW_TAPS  = 9;
   localparam int RANDOM_ITEMS = 100;
   localparam int FILL_WIDTH   = 16;
   localparam int FILL_LEFT    = 25;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_payload_type           rsp_payload;

   box_filter_3x3_mean_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // pixel model state
   logic [HEIGHT_BITS-1:0] upper_row  [MAX_WIDTH_DEFAULT];
   logic [HEIGHT_BITS-1:0] middle_row [MAX_WIDTH_DEFAULT];
   logic [HEIGHT_BITS-1:0] win        [3][3];
   logic [CFG_BITS-1:0]    cfg_width;
   logic [CFG_BITS-1:0]    cfg_height;
   int                     in_col, in_row, out_col, out_row, pend;

   req_payload_type        req_backlog[$];
   rsp_payload_type        expected_pixels[$];
   rsp_payload_type        oldest_expected;
   bit                     req_taken;
   bit                     send_hold;
   bit                     calm;
   bit                     stall_request;
   int                     hold_cycles;
   int                     mismatches;
   int                     items_queued;
   int unsigned            cycle_count;

   function automatic int clamp_size(input logic [CFG_BITS-1:0] v, input int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic void filter_reset();
      int i, j;
      for (i = 0; i < MAX_WIDTH_DEFAULT; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            win[i][j] = '0;
      cfg_width  = FRAME_SIZE_RESET;
      cfg_height = FRAME_SIZE_RESET;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      pend    = 0;
   endfunction

   function automatic void filter_predict(input req_payload_type it);
      int                     w, h, c, i, j, sum;
      logic [HEIGHT_BITS-1:0] a, b, v;
      bit                     at_start, fire;
      rsp_payload_type        r;
      w = clamp_size(cfg_width, MAX_WIDTH_DEFAULT);
      h = clamp_size(cfg_height, HEIGHT_LIMIT);
      at_start = (in_row == 0) && (in_col == 0);
      fire = 1'b0;
      v = '0;
      if (it.mode == MODE_DRAIN) begin
         if (pend != 0 && at_start) begin
            c = (out_col < MAX_WIDTH_DEFAULT) ? out_col : MAX_WIDTH_DEFAULT - 1;
            v = (out_row + 1 >= h) ? middle_row[c] : upper_row[c];
            fire = 1'b1;
         end
      end else begin
         // drop results left over from the previous frame
         if (at_start && pend != 0) begin
            pend    = 0;
            out_row = 0;
            out_col = 0;
         end
         c = (in_col < MAX_WIDTH_DEFAULT) ? in_col : MAX_WIDTH_DEFAULT - 1;
         a = upper_row[c];
         b = middle_row[c];
         upper_row[c]  = b;
         middle_row[c] = it.height;
         for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = a;
         win[1][2] = b;
         win[2][2] = it.height;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         pend++;
         if (pend > w + 1) begin
            if (out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w) begin
               v = win[1][1];
            end else begin
               sum = 0;
               for (i = 0; i < 3; i++)
                  for (j = 0; j < 3; j++)
                     sum += int'(win[i][j]);
               v = HEIGHT_BITS'(sum / WINDOW_TAPS);
            end
            fire = 1'b1;
         end
      end
      if (fire) begin
         r.filtered_height = v;
         r.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
         end
         pend--;
         expected_pixels = {expected_pixels, r};
      end
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] pick_height();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return HEIGHT_BITS'($urandom_range(0, 15));
         3: return ~HEIGHT_BITS'($urandom_range(0, 15));
         default: return HEIGHT_BITS'($urandom);
      endcase
   endfunction

   function automatic void push_pixel(input logic [HEIGHT_BITS-1:0] value);
      req_payload_type it;
      it.mode   = MODE_PIXEL;
      it.height = value;
      req_backlog = {req_backlog, it};
      items_queued++;
   endfunction

   function automatic void push_drain();
      req_payload_type it;
      it.mode   = MODE_DRAIN;
      it.height = HEIGHT_BITS'($urandom);
      req_backlog = {req_backlog, it};
      items_queued++;
   endfunction

   function automatic void queue_frame(input int w, input int h, input int drains,
                                       input bit stray);
      int n, spot, i;
      n = w * h;
      spot = (stray && n > 1) ? int'($urandom_range(1, n - 1)) : -1;
      for (i = 0; i < n; i++) begin
         if (i == spot) push_drain();
         push_pixel(pick_height());
      end
      for (i = 0; i < drains; i++) push_drain();
   endfunction

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
   endtask

   task automatic write_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
      if ($urandom_range(0, 1) == 0) begin
         write_csr(CSR_FRAME_WIDTH, w);
         write_csr(CSR_FRAME_HEIGHT, h);
      end else begin
         write_csr(CSR_FRAME_HEIGHT, h);
         write_csr(CSR_FRAME_WIDTH, w);
      end
   endtask

   // resize after k pixels, then finish the frame under the new size and flush
   task automatic run_resize(input logic [CFG_BITS-1:0] w1, input logic [CFG_BITS-1:0] h1,
                             input logic [CFG_BITS-1:0] w2, input logic [CFG_BITS-1:0] h2,
                             input int k);
      int w, h, c, r, n;
      wait_idle();
      write_size(w1, h1);
      queue_frame(k, 1, 0, 1'b0);
      wait_idle();
      write_size(w2, h2);
      w = clamp_size(w2, MAX_WIDTH_DEFAULT);
      h = clamp_size(h2, HEIGHT_LIMIT);
      c = in_col;
      r = in_row;
      n = 0;
      while (c != 0 || r != 0) begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         n++;
      end
      queue_frame(n, 1, w + 1, 1'b0);
   endtask

   task automatic run_random_phase();
      int                  w, h, frames, f;
      logic [CFG_BITS-1:0] wreg, hreg;
      case ($urandom_range(0, 19))
         0: wreg = '0;
         1, 2, 3: wreg = CFG_BITS'($urandom_range(7, 16));
         default: wreg = CFG_BITS'($urandom_range(1, 6));
      endcase
      hreg = ($urandom_range(0, 15) == 0) ? '0 : CFG_BITS'($urandom_range(1, 6));
      wait_idle();
      write_size(wreg, hreg);
      w = clamp_size(wreg, MAX_WIDTH_DEFAULT);
      h = clamp_size(hreg, HEIGHT_LIMIT);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
         case ($urandom_range(0, 9))
            0: queue_frame(w, h, w + 1, 1'b1);
            1: queue_frame(w, h, $urandom_range(0, w), 1'b0);
            2: begin
               repeat ($urandom_range(1, 3)) push_drain();
               queue_frame(w, h, w + 1 + $urandom_range(1, 3), 1'b0);
            end
            default: queue_frame(w, h, w + 1, 1'b0);
         endcase
      end
   endtask

   // record accepted items and predict their results
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         filter_predict(req_payload);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_backlog.size() != 0 && !send_hold &&
             (calm || $urandom_range(0, 99) >= 13)) begin
            req_valid   <= 1'b1;
            req_payload <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_request) begin
         stall_request = 1'b0;
         hold_cycles = LONG_HOLD;
      end
      if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: height %h frame_end %b",
                        rsp_payload.filtered_height, rsp_payload.frame_end);
         end else begin
            oldest_expected = expected_pixels.pop_front();
            if (rsp_payload.filtered_height !== oldest_expected.filtered_height ||
                rsp_payload.frame_end !== oldest_expected.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected height %h frame_end %b, got %h %b",
                           oldest_expected.filtered_height, oldest_expected.frame_end,
                           rsp_payload.filtered_height, rsp_payload.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int i, phase;
      filter_reset();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // drain with nothing pending at reset size
      push_drain();
      wait_idle();
      write_size(11'd3, 11'd3);
      for (i = 0; i < 9; i++) begin
         push_pixel((i == 2) ? 16'h0000 : 16'hFFFF);
         if (i == 4) push_drain();
      end
      repeat (4) push_drain();
      wait_idle();
      write_size(11'd0, 11'd0);
      push_pixel(16'h8001);
      push_drain();
      push_drain();

      // write both line buffers in the columns that the resize runs revisit
      wait_idle();
      write_size(CFG_BITS'(FILL_WIDTH), 11'd2);
      calm = 1'b1;
      queue_frame(FILL_WIDTH, 2, FILL_WIDTH + 1, 1'b0);
      while (req_backlog.size() > FILL_LEFT) @(negedge clock);
      send_hold = 1'b1;
      while (expected_pixels.size() != 0) @(negedge clock);
      send_hold = 1'b0;
      wait_idle();
      calm = 1'b0;

      write_size(11'd4, 11'd8);
      queue_frame(4, 8, 5, 1'b0);
      queue_frame(4, 8, 5, 1'b0);
      stall_request = 1'b1;

      run_resize(11'd2, 11'd2047, 11'd3, 11'd4, 10);
      run_resize(11'd5, 11'd1024, 11'd2, 11'd2, 17);
      run_resize(11'd4, 11'd4, 11'd0, 11'd6, 9);
      run_resize(11'd6, 11'd3, 11'd3, 11'd0, 18);
      run_resize(11'd2047, 11'd1, 11'd3, 11'd3, 12);
      run_resize(CFG_BITS'($urandom_range(1, 8)), CFG_BITS'($urandom_range(1, 8)),
                 CFG_BITS'($urandom_range(0, 8)), CFG_BITS'($urandom_range(0, 8)),
                 $urandom_range(1, 40));

      items_queued = 0;
      phase = 0;
      while (items_queued < RANDOM_ITEMS) begin
         calm = (phase >= 1 && phase < 3);
         run_random_phase();
         phase++;
      end
      wait_idle();
      calm = 1'b0;

      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
